[design/weighted_random_pick_assert.svh]
// Assertion macros used by the weighted_random_pick RTL.
`ifndef WEIGHTED_RANDOM_PICK_ASSERT_SVH
`define WEIGHTED_RANDOM_PICK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("weighted_random_pick: check failed");

// Next-cycle implication, checked outside reset.
`define WRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("weighted_random_pick: check failed");

`endif

[design/wrp_pkg.sv]
package wrp_pkg;

   // table geometry
   localparam int ENTRIES     = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int RANDOM_BITS = 16;

   // fixed field widths
   localparam int INDEX_BITS = 4;
   localparam int FIELD_BITS = 16;

   // running sum of the table never overflows this width
   localparam int TOTAL_BITS = WEIGHT_BITS + $clog2(ENTRIES);
   localparam int PROD_BITS  = TOTAL_BITS + RANDOM_BITS;

   typedef enum logic [0:0] {
      OP_WRITE,
      OP_DRAW
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_WALK,
      ST_HOLD
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [INDEX_BITS-1:0]  entry_index;
      logic [FIELD_BITS-1:0]  weight_value;
      logic [FIELD_BITS-1:0]  random_fraction;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]  picked_index;
      logic                   picked_valid;
   } rsp_type;

   // weight load into one cell
   typedef struct packed {
      logic                   en;
      logic [WEIGHT_BITS-1:0] weight;
   } wr_type;

   // draw token walking down the chain
   typedef struct packed {
      logic                   valid;
      logic                   found;
      logic [INDEX_BITS-1:0]  idx;
      logic [TOTAL_BITS-1:0]  rem;
   } token_type;

endpackage

[design/wrp_cell.sv]
module wrp_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [wrp_pkg::INDEX_BITS-1:0]  cell_id,
   input  wrp_pkg::wr_type                 wr,
   input  wrp_pkg::token_type              tok_in,
   output wrp_pkg::token_type              tok_out,
   output logic [wrp_pkg::WEIGHT_BITS-1:0] weight
);

   logic [wrp_pkg::WEIGHT_BITS-1:0] weight_ff;
   wrp_pkg::token_type              tok_ff;
   wrp_pkg::token_type              tok_in_next;
   logic [wrp_pkg::TOTAL_BITS-1:0]  weight_ext;

   assign weight_ext = wrp_pkg::TOTAL_BITS'(weight_ff);

   // stop the token here if the remainder falls inside this weight
   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.valid && !tok_in.found) begin
         if (tok_in.rem < weight_ext) begin
            tok_in_next.found = 1'b1;
            tok_in_next.idx   = cell_id;
         end else begin
            tok_in_next.rem = tok_in.rem - weight_ext;
         end
      end
   end

   // weight storage
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
      end else if (wr.en) begin
         weight_ff <= wr.weight;
      end
   end

   // token stage, only valid is cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;
   assign weight  = weight_ff;

endmodule

[design/weighted_random_pick.sv]
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | wrp_pkg::req_type (write or draw)
// rsp     | out       | rsp_valid, rsp_stall | wrp_pkg::rsp_type (one per draw)
//
// A weight write is taken and gives no result.
// A draw first scales the fraction by the total,
// then the token runs the full chain of weight cells.
// The next item is taken the cycle after a draw's result is registered.
// Reset clears all weights, the total and the control state.
// A stalled result sits in the output register; a draw finishing behind it waits.
module weighted_random_pick (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wrp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wrp_pkg::rsp_type rsp_data
);

`include "weighted_random_pick_assert.svh"

   wrp_pkg::state_type              state_ff, state_in;
   logic [wrp_pkg::RANDOM_BITS-1:0] frac_ff, frac_in;
   logic [wrp_pkg::TOTAL_BITS-1:0]  total_ff, total_in;
   wrp_pkg::token_type              inj_ff, inj_in;
   wrp_pkg::rsp_type                rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   wrp_pkg::rsp_type                fin_ff, fin_in;

   logic                            req_fire;
   logic                            rsp_fire;
   logic                            slot_free;
   logic                            wr_fire;
   logic                            wr_in_range;
   logic [wrp_pkg::WEIGHT_BITS-1:0] new_weight;
   logic [wrp_pkg::WEIGHT_BITS-1:0] old_weight;
   logic [wrp_pkg::PROD_BITS-1:0]   product;
   wrp_pkg::rsp_type                chain_rsp;

   wrp_pkg::token_type              tok [wrp_pkg::ENTRIES+1];
   logic [wrp_pkg::WEIGHT_BITS-1:0] cell_weight [wrp_pkg::ENTRIES];
   logic [wrp_pkg::ENTRIES:0]       tok_valid;

   // handshakes
   assign req_stall = (state_ff != wrp_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // weight write decode
   assign wr_fire     = req_fire && (req_data.op == wrp_pkg::OP_WRITE);
   assign wr_in_range = (32'(req_data.entry_index) < wrp_pkg::ENTRIES);
   assign new_weight  = req_data.weight_value[wrp_pkg::WEIGHT_BITS-1:0];

   // old weight of the addressed entry
   always_comb begin
      old_weight = '0;
      for (int i = 0; i < wrp_pkg::ENTRIES; i++) begin
         if (32'(req_data.entry_index) == i) begin
            old_weight = cell_weight[i];
         end
      end
   end

   // running total
   always_comb begin
      total_in = total_ff;
      if (wr_fire && wr_in_range) begin
         total_in = total_ff - wrp_pkg::TOTAL_BITS'(old_weight)
                  + wrp_pkg::TOTAL_BITS'(new_weight);
      end
   end

   // selection = floor(total * fraction / 2^RANDOM_BITS)
   assign product = wrp_pkg::PROD_BITS'(total_ff) * wrp_pkg::PROD_BITS'(frac_ff);

   // chain output as a result
   assign chain_rsp.picked_index = tok[wrp_pkg::ENTRIES].found ?
                                   tok[wrp_pkg::ENTRIES].idx : '0;
   assign chain_rsp.picked_valid = tok[wrp_pkg::ENTRIES].found;

   // sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      frac_in      = frac_ff;
      inj_in       = inj_ff;
      inj_in.valid = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      fin_in       = fin_ff;
      case (state_ff)
         wrp_pkg::ST_IDLE: begin
            if (req_fire && (req_data.op == wrp_pkg::OP_DRAW)) begin
               frac_in  = req_data.random_fraction[wrp_pkg::RANDOM_BITS-1:0];
               state_in = wrp_pkg::ST_SCALE;
            end
         end
         wrp_pkg::ST_SCALE: begin
            inj_in.valid = 1'b1;
            inj_in.found = 1'b0;
            inj_in.idx   = '0;
            inj_in.rem   = product[wrp_pkg::PROD_BITS-1:wrp_pkg::RANDOM_BITS];
            state_in     = wrp_pkg::ST_WALK;
         end
         wrp_pkg::ST_WALK: begin
            if (tok[wrp_pkg::ENTRIES].valid) begin
               if (slot_free) begin
                  rsp_in       = chain_rsp;
                  rsp_valid_in = 1'b1;
                  state_in     = wrp_pkg::ST_IDLE;
               end else begin
                  fin_in   = chain_rsp;
                  state_in = wrp_pkg::ST_HOLD;
               end
            end
         end
         wrp_pkg::ST_HOLD: begin
            if (slot_free) begin
               rsp_in       = fin_ff;
               rsp_valid_in = 1'b1;
               state_in     = wrp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrp_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrp_pkg::ST_IDLE;
         total_ff     <= '0;
         inj_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         inj_ff       <= inj_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      frac_ff <= frac_in;
      rsp_ff  <= rsp_in;
      fin_ff  <= fin_in;
   end

   // chain of weight cells, token enters at cell 0
   assign tok[0]       = inj_ff;
   assign tok_valid[0] = inj_ff.valid;

   for (genvar g = 0; g < wrp_pkg::ENTRIES; g++) begin : g_cell
      wrp_pkg::wr_type cell_wr;

      assign cell_wr.en     = wr_fire && (32'(req_data.entry_index) == g);
      assign cell_wr.weight = new_weight;

      wrp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (wrp_pkg::INDEX_BITS'(g)),
         .wr      (cell_wr),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1]),
         .weight  (cell_weight[g])
      );

      assign tok_valid[g+1] = tok[g+1].valid;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `WRP_ASSERT_NOW(a_one_token, clock, reset, 1'b1, $onehot0(tok_valid))
   `WRP_ASSERT_NOW(a_exit_in_walk, clock, reset, tok[wrp_pkg::ENTRIES].valid, state_ff == wrp_pkg::ST_WALK)
   `WRP_ASSERT_NOW(a_nonzero_hits, clock, reset, tok[wrp_pkg::ENTRIES].valid && (total_ff != '0), tok[wrp_pkg::ENTRIES].found)
   `WRP_ASSERT_NOW(a_nopick_zero, clock, reset, rsp_valid_ff && !rsp_ff.picked_valid, rsp_ff.picked_index == '0)
   `WRP_ASSERT_NEXT(a_scale_injects, clock, reset, state_ff == wrp_pkg::ST_SCALE, inj_ff.valid)

endmodule
